// ----- design/openpgp_packet_header_parser_top_assert.svh -----
// ----------------------------------------------------------------------------
// OpenPGP packet header parser assertion macros
// Concurrent check macros shared by the parser modules; clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef OPENPGP_PACKET_HEADER_PARSER_TOP_ASSERT_SVH
`define OPENPGP_PACKET_HEADER_PARSER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define OPHP_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("ophp assertion failed");
`define OPHP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ophp assertion failed");
`define OPHP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ophp assertion failed");
`else
`define OPHP_ASSERT_ALWAYS(lbl, cond)
`define OPHP_ASSERT_IMPL(lbl, ante, cons)
`define OPHP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/ophp_pkg.sv -----
// ----------------------------------------------------------------------------
// OpenPGP packet header parser package
// Shared types, codes and constants for the front, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package ophp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_NEWLEN = 3'd1,
        PH_LENB   = 3'd2,
        PH_NEW2   = 3'd3,
        PH_SKIP   = 3'd4,
        PH_BODY   = 3'd5,
        PH_HALT   = 3'd6
    } t_phase;

    typedef enum logic [3:0] {
        ST_PROGRESS      = 4'd0,
        ST_SKIPPED       = 4'd1,
        ST_BODY          = 4'd2,
        ST_FOUND         = 4'd3,
        ST_STOP          = 4'd4,
        ST_NOT_FOUND     = 4'd5,
        ST_NOT_PACKET    = 4'd6,
        ST_PARTIAL       = 4'd7,
        ST_INDETERMINATE = 4'd8,
        ST_TRUNCATED     = 4'd9
    } t_status;

    typedef enum logic {
        CFG_WANT_TYPE = 1'b0,
        CFG_STOP_TYPE = 1'b1
    } t_cfg_idx;

    localparam logic [5:0] WANT_ANY        = 6'd0;
    localparam logic [7:0] STOP_RESET      = 8'hFF;
    localparam logic [1:0] OLD_LT_INDET    = 2'b11;
    localparam logic [7:0] LEN_FIVE        = 8'hFF;
    localparam logic [7:0] LEN_PARTIAL_MIN = 8'd224;
    localparam logic [7:0] LEN_TWO_MIN     = 8'd192;
    localparam logic [2:0] LENB_FOUR       = 3'd4;
    localparam logic [2:0] LENB_LAST       = 3'd1;

    typedef struct packed {
        logic [5:0] want_type;
        logic [7:0] stop_type;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data;
        logic       eoi;
        logic       is_hdr;
        logic       is_new;
        logic [5:0] hdr_type;
        logic [1:0] old_lt;
        logic       len_five;
        logic       len_part;
        logic       len_two;
    } t_item;

endpackage

`default_nettype wire

// ----- design/openpgp_packet_header_parser_top.sv -----
// ----------------------------------------------------------------------------
// OpenPGP packet header parser
// Input channel (i_valid/o_ready) carries one stream byte per item, with
// i_end_of_input marking the end of the stream. Output channel
// (o_valid/i_ready) returns exactly one result item per input item: status,
// current packet type, decoded body length, body byte and a last flag.
// Configuration: i_cfg_we writes want_type (index 0) or stop_type (index 1)
// from i_cfg_data; write only while no item is in flight.
// Throughput is one item per cycle while the receiver does not stall.
// An accepted byte is written into the queue, then the back end steps it
// and updates all of its state along with the output register.
// Reset (synchronous, active low) clears the queue, the parser state and the
// output valid flag, and sets want_type to 0 and stop_type to 255.
// When the receiver stalls, the result stays in the output register, the
// back end holds, and the queue of P_QDEPTH items fills before o_ready drops.
// After a terminal status the parser repeats it with last set until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module openpgp_packet_header_parser_top
    import ophp_pkg::*;
#(
    parameter int P_QDEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_input,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_status,
    output logic [5:0]       o_packet_type,
    output logic [31:0]      o_packet_length,
    output logic [7:0]       o_body_byte,
    output logic             o_last,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data
);

    t_item fr_item;
    t_item q_item;
    t_cfg  cfg;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;

    ophp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_item         (fr_item),
        .o_cfg          (cfg)
    );

    ophp_fifo #(
        .DEPTH (P_QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (fr_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ophp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_item          (q_item),
        .i_q_empty       (q_empty),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_packet_type   (o_packet_type),
        .o_packet_length (o_packet_length),
        .o_body_byte     (o_body_byte),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

// ----- design/ophp_front.sv -----
// ----------------------------------------------------------------------------
// OpenPGP packet header parser front end
// Holds the configuration registers and classifies each accepted byte
// before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ophp_front
    import ophp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_input,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_item           o_item,
    output t_cfg            o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.want_type <= WANT_ANY;
            r_cfg.stop_type <= STOP_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WANT_TYPE: r_cfg.want_type <= i_cfg_data[5:0];
                CFG_STOP_TYPE: r_cfg.stop_type <= i_cfg_data;
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign o_cfg   = r_cfg;

    always_comb begin
        o_item.data     = i_data_byte;
        o_item.eoi      = i_end_of_input;
        o_item.is_hdr   = i_data_byte[7];
        o_item.is_new   = i_data_byte[6];
        o_item.hdr_type = i_data_byte[6] ? i_data_byte[5:0] : {2'b00, i_data_byte[5:2]};
        o_item.old_lt   = i_data_byte[1:0];
        o_item.len_five = (i_data_byte == LEN_FIVE);
        o_item.len_part = (i_data_byte >= LEN_PARTIAL_MIN) && (i_data_byte != LEN_FIVE);
        o_item.len_two  = (i_data_byte >= LEN_TWO_MIN) && (i_data_byte < LEN_PARTIAL_MIN);
    end

endmodule

`default_nettype wire

// ----- design/ophp_fifo.sv -----
// ----------------------------------------------------------------------------
// OpenPGP packet header parser item queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "openpgp_packet_header_parser_top_assert.svh"

module ophp_fifo
    import ophp_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output t_item      o_item,
    output logic       o_full,
    output logic       o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `OPHP_ASSERT_ALWAYS(a_no_overflow, !(i_push && o_full && !i_pop))
    `OPHP_ASSERT_ALWAYS(a_no_underflow, !(i_pop && o_empty))

endmodule

`default_nettype wire

// ----- design/ophp_back.sv -----
// ----------------------------------------------------------------------------
// OpenPGP packet header parser back end
// Runs the header/body state machine on queued items and holds the result
// in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "openpgp_packet_header_parser_top_assert.svh"

module ophp_back
    import ophp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire t_item       i_item,
    input  wire logic        i_q_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_status,
    output logic [5:0]       o_packet_type,
    output logic [31:0]      o_packet_length,
    output logic [7:0]       o_body_byte,
    output logic             o_last
);

    t_phase      r_phase, n_phase;
    t_status     r_held, n_held;
    logic [5:0]  r_type, n_type;
    logic [31:0] r_accum, n_accum;
    logic [2:0]  r_left, n_left;
    logic [7:0]  r_first, n_first;
    logic [31:0] r_body_left, n_body_left;

    t_status     n_status;
    logic [7:0]  n_body;
    logic        n_body_last;

    logic        r_out_valid;
    t_status     r_out_status;
    logic [5:0]  r_out_type;
    logic [31:0] r_out_len;
    logic [7:0]  r_out_body;
    logic        r_out_last;

    logic        step;
    logic        wanted;
    logic        stop_hit;
    logic        hdr_end;
    logic        hd_zero;
    logic        body_end;
    logic [31:0] hd_len;
    logic [7:0]  first_off;

    assign step     = !i_q_empty && (!r_out_valid || i_ready);
    assign o_pop    = step;
    assign wanted   = (i_cfg.want_type == WANT_ANY) || (r_type == i_cfg.want_type);
    assign stop_hit = ({2'b00, i_item.hdr_type} == i_cfg.stop_type);
    assign body_end = (r_body_left == 32'd1);
    assign first_off = r_first - LEN_TWO_MIN;

    always_comb begin
        case (r_phase)
            PH_NEW2: hd_len = 32'({first_off, i_item.data}) + 32'(LEN_TWO_MIN);
            PH_LENB: hd_len = {r_accum[23:0], i_item.data};
            default: hd_len = {24'd0, i_item.data};
        endcase
    end

    assign hd_zero = (hd_len == '0);
    assign hdr_end = ((r_phase == PH_NEWLEN) && !i_item.len_five && !i_item.len_part
                      && !i_item.len_two)
                  || (r_phase == PH_NEW2)
                  || ((r_phase == PH_LENB) && (r_left == LENB_LAST));

    // next state
    always_comb begin
        n_phase = r_phase;
        if (r_phase == PH_HALT || i_item.eoi) begin
            n_phase = PH_HALT;
        end else if (hdr_end) begin
            if (wanted) begin
                n_phase = hd_zero ? PH_HALT : PH_BODY;
            end else begin
                n_phase = hd_zero ? PH_IDLE : PH_SKIP;
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (!i_item.is_hdr || stop_hit) begin
                        n_phase = PH_HALT;
                    end else if (i_item.is_new) begin
                        n_phase = PH_NEWLEN;
                    end else if (i_item.old_lt == OLD_LT_INDET) begin
                        n_phase = PH_HALT;
                    end else begin
                        n_phase = PH_LENB;
                    end
                end
                PH_NEWLEN: begin
                    if (i_item.len_five) begin
                        n_phase = PH_LENB;
                    end else if (i_item.len_part) begin
                        n_phase = PH_HALT;
                    end else begin
                        n_phase = PH_NEW2;
                    end
                end
                PH_SKIP: n_phase = body_end ? PH_IDLE : PH_SKIP;
                PH_BODY: n_phase = body_end ? PH_HALT : PH_BODY;
                default: n_phase = r_phase;
            endcase
        end
    end

    // outputs and datapath
    always_comb begin
        n_status    = ST_PROGRESS;
        n_body      = '0;
        n_body_last = 1'b0;
        n_type      = r_type;
        n_accum     = r_accum;
        n_left      = r_left;
        n_first     = r_first;
        n_body_left = r_body_left;
        n_held      = r_held;
        if (r_phase == PH_HALT) begin
            n_status = r_held;
        end else if (i_item.eoi) begin
            n_status = (r_phase == PH_IDLE || r_phase == PH_SKIP) ? ST_NOT_FOUND
                                                                  : ST_TRUNCATED;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    n_accum = '0;
                    if (!i_item.is_hdr) begin
                        n_type   = '0;
                        n_status = ST_NOT_PACKET;
                    end else begin
                        n_type = i_item.hdr_type;
                        if (stop_hit) begin
                            n_status = ST_STOP;
                        end else if (!i_item.is_new) begin
                            if (i_item.old_lt == OLD_LT_INDET) begin
                                n_status = ST_INDETERMINATE;
                            end else begin
                                n_left = 3'(3'd1 << i_item.old_lt);
                            end
                        end
                    end
                end
                PH_NEWLEN: begin
                    if (i_item.len_five) begin
                        n_left = LENB_FOUR;
                    end else if (i_item.len_part) begin
                        n_status = ST_PARTIAL;
                    end else if (i_item.len_two) begin
                        n_first = i_item.data;
                    end
                end
                PH_LENB: begin
                    n_accum = hd_len;
                    n_left  = r_left - 1'b1;
                end
                PH_SKIP: begin
                    n_status    = ST_SKIPPED;
                    n_body_left = r_body_left - 1'b1;
                end
                PH_BODY: begin
                    n_status    = ST_BODY;
                    n_body      = i_item.data;
                    n_body_left = r_body_left - 1'b1;
                    n_body_last = body_end;
                end
                default: n_status = r_held;
            endcase
            if (hdr_end) begin
                n_accum     = hd_len;
                n_body_left = hd_len;
                if (hd_zero) begin
                    n_status = wanted ? ST_FOUND : ST_SKIPPED;
                end
            end
        end
        if (r_phase != PH_HALT && n_phase == PH_HALT) begin
            n_held = (r_phase == PH_BODY && !i_item.eoi) ? ST_FOUND : n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_held      <= ST_PROGRESS;
            r_type      <= '0;
            r_accum     <= '0;
            r_left      <= '0;
            r_first     <= '0;
            r_body_left <= '0;
        end else if (step) begin
            r_phase     <= n_phase;
            r_held      <= n_held;
            r_type      <= n_type;
            r_accum     <= n_accum;
            r_left      <= n_left;
            r_first     <= n_first;
            r_body_left <= n_body_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_status <= n_status;
            r_out_type   <= n_type;
            r_out_len    <= n_accum;
            r_out_body   <= n_body;
            r_out_last   <= n_body_last || (n_status >= ST_FOUND);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_packet_type   = r_out_type;
    assign o_packet_length = r_out_len;
    assign o_body_byte     = r_out_body;
    assign o_last          = r_out_last;

    `OPHP_ASSERT_NEXT(a_halt_sticks, r_phase == PH_HALT, r_phase == PH_HALT)
    `OPHP_ASSERT_IMPL(a_term_last, r_out_valid && (r_out_status >= ST_FOUND), r_out_last)

endmodule

`default_nettype wire

// ----- sim/openpgp_packet_header_parser_checker.sv -----
// ----------------------------------------------------------------------------
// OpenPGP packet header parser checker
// Watches the byte and result channels and the register port, tracks the
// parser state for every accepted byte and compares each accepted result,
// field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module openpgp_packet_header_parser_checker
    import ophp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_input,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [3:0]  i_status,
    input  logic [5:0]  i_packet_type,
    input  logic [31:0] i_packet_length,
    input  logic [7:0]  i_body_byte,
    input  logic        i_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    output int          o_pending,
    output int          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_status     status;
        logic [5:0]  ptype;
        logic [31:0] plen;
        logic [7:0]  body;
        logic        last;
    } t_parse_result;

    t_parse_result pending_replies[$];

    logic [5:0]  want_type_r;
    logic [7:0]  stop_type_r;
    t_phase      ph;
    t_status     held;
    logic [5:0]  cur_type;
    logic [31:0] len_acc;
    logic [2:0]  len_left;
    logic [7:0]  first_len;
    logic [31:0] body_left;
    logic        wanted;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= 20) begin
            $display("%0t ns: result mismatch: %s", $time, msg);
        end
    endtask

    function automatic t_status halt_on(input t_status s);
        ph   = PH_HALT;
        held = s;
        return s;
    endfunction

    function automatic t_status close_header();
        wanted    = (want_type_r == WANT_ANY) || (cur_type == want_type_r);
        body_left = len_acc;
        if (wanted) begin
            if (len_acc == 32'd0) begin
                return halt_on(ST_FOUND);
            end
            ph = PH_BODY;
            return ST_PROGRESS;
        end
        if (len_acc == 32'd0) begin
            ph = PH_IDLE;
            return ST_SKIPPED;
        end
        ph = PH_SKIP;
        return ST_PROGRESS;
    endfunction

    function automatic t_parse_result parse_stream_byte(input logic [7:0] b, input logic eoi);
        t_parse_result r;
        r.status = ST_PROGRESS;
        r.body   = 8'd0;
        r.last   = 1'b0;
        if (ph == PH_HALT) begin
            r.status = held;
        end else if (eoi) begin
            r.status = halt_on((ph == PH_IDLE || ph == PH_SKIP) ? ST_NOT_FOUND : ST_TRUNCATED);
        end else begin
            case (ph)
                PH_IDLE: begin
                    len_acc = 32'd0;
                    if (!b[7]) begin
                        cur_type = 6'd0;
                        r.status = halt_on(ST_NOT_PACKET);
                    end else begin
                        cur_type = b[6] ? b[5:0] : {2'b00, b[5:2]};
                        if ({2'b00, cur_type} == stop_type_r) begin
                            r.status = halt_on(ST_STOP);
                        end else if (b[6]) begin
                            ph = PH_NEWLEN;
                        end else if (b[1:0] == OLD_LT_INDET) begin
                            r.status = halt_on(ST_INDETERMINATE);
                        end else begin
                            len_left = 3'd1 << b[1:0];
                            ph       = PH_LENB;
                        end
                    end
                end
                PH_NEWLEN: begin
                    if (b == LEN_FIVE) begin
                        len_left = LENB_FOUR;
                        ph       = PH_LENB;
                    end else if (b >= LEN_PARTIAL_MIN) begin
                        r.status = halt_on(ST_PARTIAL);
                    end else if (b >= LEN_TWO_MIN) begin
                        first_len = b;
                        ph        = PH_NEW2;
                    end else begin
                        len_acc  = {24'd0, b};
                        r.status = close_header();
                    end
                end
                PH_NEW2: begin
                    len_acc  = {16'd0, first_len - LEN_TWO_MIN, 8'd0} + {24'd0, b}
                             + {24'd0, LEN_TWO_MIN};
                    r.status = close_header();
                end
                PH_LENB: begin
                    len_acc  = {len_acc[23:0], b};
                    len_left = len_left - 3'd1;
                    if (len_left == 3'd0) begin
                        r.status = close_header();
                    end
                end
                PH_SKIP: begin
                    r.status  = ST_SKIPPED;
                    body_left = body_left - 32'd1;
                    if (body_left == 32'd0) begin
                        ph = PH_IDLE;
                    end
                end
                PH_BODY: begin
                    r.status  = ST_BODY;
                    r.body    = b;
                    body_left = body_left - 32'd1;
                    if (body_left == 32'd0) begin
                        r.last = 1'b1;
                        ph     = PH_HALT;
                        held   = ST_FOUND;
                    end
                end
                default: begin
                    r.status = halt_on(ST_NOT_FOUND);
                end
            endcase
        end
        if (r.status >= ST_FOUND) begin
            r.last = 1'b1;
        end
        r.ptype = cur_type;
        r.plen  = len_acc;
        return r;
    endfunction

    task automatic check_result(input t_parse_result x);
        if (i_status !== x.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", i_status, x.status));
        end
        if (i_packet_type !== x.ptype) begin
            report_mismatch($sformatf("packet_type %0d, expected %0d", i_packet_type, x.ptype));
        end
        if (i_packet_length !== x.plen) begin
            report_mismatch($sformatf("packet_length %0d, expected %0d",
                                      i_packet_length, x.plen));
        end
        if (i_body_byte !== x.body) begin
            report_mismatch($sformatf("body_byte %0h, expected %0h", i_body_byte, x.body));
        end
        if (i_last !== x.last) begin
            report_mismatch($sformatf("last %0b, expected %0b", i_last, x.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pending_replies.delete();
            want_type_r = WANT_ANY;
            stop_type_r = STOP_RESET;
            ph          = PH_IDLE;
            held        = ST_PROGRESS;
            cur_type    = 6'd0;
            len_acc     = 32'd0;
            len_left    = 3'd0;
            first_len   = 8'd0;
            body_left   = 32'd0;
            wanted      = 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WANT_TYPE) begin
                    want_type_r = i_cfg_data[5:0];
                end else begin
                    stop_type_r = i_cfg_data;
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_replies.push_back(parse_stream_byte(i_data_byte, i_end_of_input));
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch("result with no byte outstanding");
                end else begin
                    check_result(pending_replies.pop_front());
                end
            end
        end
        o_pending = pending_replies.size();
    end

endmodule

// ----- sim/tb_openpgp_packet_header_parser_top.sv -----
// ----------------------------------------------------------------------------
// OpenPGP packet header parser testbench
// Feeds packet streams in every header format with random bodies, moves the
// type filters between phases, varies sender gaps and receiver stalls, and
// ends each run with one randomly chosen terminal case followed by bytes sent
// into the halted parser. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_openpgp_packet_header_parser_top;
    import ophp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_BYTES  = 450;

    typedef enum int {
        FORM_OLD1, FORM_OLD2, FORM_OLD4, FORM_NEW1, FORM_NEW2, FORM_NEW5
    } t_hdr_form;

    typedef enum int {
        END_DELIVER, END_EMPTY, END_STOP, END_NOT_PACKET, END_INDET,
        END_PARTIAL, END_EOI_IDLE, END_EOI_SKIP, END_EOI_HEADER, END_EOI_BODY
    } t_end_case;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        end_of_input;
    logic        out_valid;
    logic        rx_ready = 1'b0;
    logic [3:0]  status;
    logic [5:0]  packet_type;
    logic [31:0] packet_length;
    logic [7:0]  body_byte;
    logic        last;
    logic        cfg_we;
    t_cfg_idx    cfg_idx;
    logic [7:0]  cfg_data;

    int          pending;
    int          fail_count;
    int          send_idle_pct;
    int          stall_pct;
    int          bytes_sent;
    int          quiet_cycles;
    logic [5:0]  cur_want;
    logic [7:0]  cur_stop;

    logic [5:0]  w;
    logic [7:0]  s;
    logic [5:0]  t;
    int unsigned blen;
    int          target;
    t_hdr_form   f;
    t_end_case   ec;

    openpgp_packet_header_parser_top u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_ready         (in_ready),
        .i_data_byte     (data_byte),
        .i_end_of_input  (end_of_input),
        .o_valid         (out_valid),
        .i_ready         (rx_ready),
        .o_status        (status),
        .o_packet_type   (packet_type),
        .o_packet_length (packet_length),
        .o_body_byte     (body_byte),
        .o_last          (last),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    openpgp_packet_header_parser_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_data_byte     (data_byte),
        .i_end_of_input  (end_of_input),
        .i_out_valid     (out_valid),
        .i_out_ready     (rx_ready),
        .i_status        (status),
        .i_packet_type   (packet_type),
        .i_packet_length (packet_length),
        .i_body_byte     (body_byte),
        .i_last          (last),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk) begin
        rx_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && rx_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("openpgp_packet_header_parser_top regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 84; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 84; end
            default: begin send_idle_pct = 19; stall_pct = 19; end
        endcase
    endtask

    task automatic push_item(input logic [7:0] b, input logic eoi);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        end_of_input <= eoi;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // hold valid low and wait until every result has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic program_filter(input logic [5:0] want, input logic [7:0] stop);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WANT_TYPE;
        cfg_data <= {2'b00, want};
        @(negedge clk);
        cfg_idx  <= CFG_STOP_TYPE;
        cfg_data <= stop;
        @(negedge clk);
        cfg_we   <= 1'b0;
        cur_want = want;
        cur_stop = stop;
    endtask

    function automatic t_hdr_form pick_form(input logic [5:0] ptype, input int unsigned len);
        t_hdr_form fm;
        bit        ok;
        do begin
            fm = t_hdr_form'($urandom_range(0, 5));
            case (fm)
                FORM_OLD1: ok = (ptype <= 6'd15) && (len <= 255);
                FORM_OLD2: ok = (ptype <= 6'd15) && (len <= 65535);
                FORM_OLD4: ok = (ptype <= 6'd15);
                FORM_NEW1: ok = (len <= 191);
                FORM_NEW2: ok = (len >= 192) && (len <= 8383);
                default:   ok = 1'b1;
            endcase
        end while (!ok);
        return fm;
    endfunction

    // any type other than the current want type and stop type
    function automatic logic [5:0] pick_type(input bit old_form);
        logic [5:0] pt;
        do begin
            pt = old_form ? 6'($urandom_range(0, 15)) : 6'($urandom_range(0, 63));
        end while (pt == cur_want || {2'b00, pt} == cur_stop);
        return pt;
    endfunction

    task automatic send_header(input logic [5:0] ptype, input t_hdr_form fm,
                               input int unsigned len);
        logic [31:0] l;
        logic [15:0] v;
        l = len;
        v = 16'(len - 192);
        case (fm)
            FORM_OLD1: begin
                push_item({2'b10, ptype[3:0], 2'b00}, 1'b0);
                push_item(l[7:0], 1'b0);
            end
            FORM_OLD2: begin
                push_item({2'b10, ptype[3:0], 2'b01}, 1'b0);
                push_item(l[15:8], 1'b0);
                push_item(l[7:0], 1'b0);
            end
            FORM_OLD4: begin
                push_item({2'b10, ptype[3:0], 2'b10}, 1'b0);
                push_item(l[31:24], 1'b0);
                push_item(l[23:16], 1'b0);
                push_item(l[15:8], 1'b0);
                push_item(l[7:0], 1'b0);
            end
            FORM_NEW1: begin
                push_item({2'b11, ptype}, 1'b0);
                push_item(l[7:0], 1'b0);
            end
            FORM_NEW2: begin
                push_item({2'b11, ptype}, 1'b0);
                push_item(LEN_TWO_MIN + {3'd0, v[12:8]}, 1'b0);
                push_item(v[7:0], 1'b0);
            end
            default: begin
                push_item({2'b11, ptype}, 1'b0);
                push_item(LEN_FIVE, 1'b0);
                push_item(l[31:24], 1'b0);
                push_item(l[23:16], 1'b0);
                push_item(l[15:8], 1'b0);
                push_item(l[7:0], 1'b0);
            end
        endcase
    endtask

    task automatic send_body(input int unsigned n);
        repeat (n) push_item(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_random_packet();
        int unsigned len;
        int          r;
        t_hdr_form   fm;
        logic [5:0]  pt;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            len = 0;
        end else if (r < 85) begin
            len = $urandom_range(1, 12);
        end else if (r < 97) begin
            len = $urandom_range(13, 191);
        end else begin
            len = $urandom_range(192, 400);
        end
        fm = pick_form(6'd0, len);
        pt = pick_type(fm <= FORM_OLD4);
        send_header(pt, fm, len);
        send_body(len);
    endtask

    initial begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = 8'd0;
        end_of_input  = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_WANT_TYPE;
        cfg_data      = 8'd0;
        bytes_sent    = 0;
        quiet_cycles  = 0;
        cur_want      = WANT_ANY;
        cur_stop      = STOP_RESET;
        set_idling(0);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        program_filter(6'h3F, 8'd0);
        send_header(6'd15, FORM_OLD1, 0);
        send_header(6'd1,  FORM_OLD2, 0);
        send_header(6'd2,  FORM_OLD4, 0);
        send_header(6'd62, FORM_NEW1, 0);
        send_header(6'd1,  FORM_NEW5, 0);
        send_header(6'd62, FORM_NEW1, 2);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        send_header(6'd3,  FORM_OLD1, 1);
        send_body(1);

        for (int m = 0; m < 4; m++) begin
            settle();
            w = 6'($urandom_range(1, 62));
            case (m)
                0: program_filter(w, STOP_RESET);
                1: program_filter(6'h3F, 8'($urandom_range(64, 254)));
                2: begin
                    do s = 8'($urandom_range(1, 63)); while (s[5:0] == w);
                    program_filter(w, s);
                end
                default: program_filter(w, 8'd0);
            endcase
            set_idling(m);
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) send_random_packet();
        end

        ec = t_end_case'($urandom_range(0, 9));
        settle();
        w = $urandom_range(0, 1) ? WANT_ANY : 6'($urandom_range(1, 62));
        if (ec == END_EOI_SKIP) begin
            w = 6'($urandom_range(1, 62));
        end
        s = (ec == END_STOP) ? 8'($urandom_range(0, 63)) : STOP_RESET;
        program_filter(w, s);
        set_idling($urandom_range(0, 3));
        if (w != WANT_ANY) begin
            repeat ($urandom_range(1, 3)) send_random_packet();
        end
        case (ec)
            END_DELIVER, END_EMPTY, END_EOI_BODY: begin
                t    = (w == WANT_ANY) ? pick_type(1'b0) : w;
                blen = (ec == END_EMPTY) ? 0 : $urandom_range(2, 20);
                send_header(t, pick_form(t, blen), blen);
                if (ec == END_EOI_BODY) begin
                    send_body($urandom_range(1, blen - 1));
                    push_item(8'($urandom_range(0, 255)), 1'b1);
                end else begin
                    send_body(blen);
                end
            end
            END_STOP: begin
                t = s[5:0];
                if (t <= 6'd15 && $urandom_range(0, 1)) begin
                    push_item({2'b10, t[3:0], 2'($urandom_range(0, 3))}, 1'b0);
                end else begin
                    push_item({2'b11, t}, 1'b0);
                end
            end
            END_NOT_PACKET: push_item({1'b0, 7'($urandom_range(0, 127))}, 1'b0);
            END_INDET: begin
                t = pick_type(1'b1);
                push_item({2'b10, t[3:0], OLD_LT_INDET}, 1'b0);
            end
            END_PARTIAL: begin
                push_item({2'b11, pick_type(1'b0)}, 1'b0);
                push_item(8'($urandom_range(224, 254)), 1'b0);
            end
            END_EOI_IDLE: push_item(8'($urandom_range(0, 255)), 1'b1);
            END_EOI_SKIP: begin
                blen = $urandom_range(2, 12);
                f    = pick_form(6'd0, blen);
                send_header(pick_type(f <= FORM_OLD4), f, blen);
                send_body($urandom_range(1, blen - 1));
                push_item(8'($urandom_range(0, 255)), 1'b1);
            end
            default: begin
                push_item({2'b11, pick_type(1'b0)}, 1'b0);
                if ($urandom_range(0, 1)) begin
                    push_item(LEN_FIVE, 1'b0);
                end
                push_item(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
        // the parser is halted now: every further byte repeats the held status
        repeat ($urandom_range(20, 40)) begin
            push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end

        settle();
        repeat (10) @(negedge clk);
        if (fail_count == 0) begin
            $display("openpgp_packet_header_parser_top regression: pass");
        end else begin
            $display("openpgp_packet_header_parser_top regression: fail");
        end
        $finish;
    end

endmodule
